// ----- src/r2fft_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package r2fft_pkg;
	localparam int MaxPointsDefault = 64;
	localparam int DataW = 30;
	localparam int InW = 24;
	localparam int TwW = 16;
	localparam int TwLog2 = 12;
	localparam int TwSpan = 4096;
	localparam logic signed [DataW-1:0] VMax = 30'sh1fffffff;
	localparam logic signed [DataW-1:0] VMin = 30'sh20000000;

	typedef logic signed [31:0] q30_t;
	typedef struct packed {
		logic signed [TwW-1:0] re;
		logic signed [TwW-1:0] im;
	} tw_t;

	function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] x,
		input int s);
		logic signed [63:0] r;
		begin
			r = (x + (64'sd1 <<< (s - 1))) >>> s;
			return r;
		end
	endfunction

	function automatic q30_t tw_cos(input int j);
		case (j)
			0: return 32'sd1073740561;
			1: return 32'sd1073736771;
			2: return 32'sd1073721611;
			3: return 32'sd1073660973;
			4: return 32'sd1073418433;
			5: return 32'sd1072448455;
			6: return 32'sd1068571464;
			7: return 32'sd1053110176;
			8: return 32'sd992008094;
			9: return 32'sd759250125;
			10: return 32'sd0;
			default: return -32'sd1073741824;
		endcase
	endfunction

	function automatic q30_t tw_sin(input int j);
		case (j)
			0: return 32'sd1647099;
			1: return 32'sd3294193;
			2: return 32'sd6588356;
			3: return 32'sd13176464;
			4: return 32'sd26350944;
			5: return 32'sd52686014;
			6: return 32'sd105245103;
			7: return 32'sd209476638;
			8: return 32'sd410903207;
			9: return 32'sd759250125;
			10: return 32'sd1073741824;
			default: return 32'sd0;
		endcase
	endfunction

	// elaboration-time twiddle evaluation; used only to fill a constant rom
	function automatic tw_t twiddle(input int t);
		logic signed [63:0] a, b, na, nb, c, s, wr, wi;
		tw_t w;
		begin
			a = 64'sd1 <<< 30;
			b = 64'sd0;
			for (int j = 0; j < TwLog2; j++) begin
				if (((t >> j) & 1) != 0) begin
					c = 64'(tw_cos(j));
					s = 64'(tw_sin(j));
					na = rnd_shift(a * c + b * s, 30);
					nb = rnd_shift(b * c - a * s, 30);
					a = na;
					b = nb;
				end
			end
			wr = rnd_shift(a, 15);
			wi = rnd_shift(b, 15);
			if (wr > 64'sd32767) wr = 64'sd32767;
			if (wr < -64'sd32768) wr = -64'sd32768;
			if (wi > 64'sd32767) wi = 64'sd32767;
			if (wi < -64'sd32768) wi = -64'sd32768;
			w.re = wr[TwW-1:0];
			w.im = wi[TwW-1:0];
			return w;
		end
	endfunction

	function automatic logic signed [DataW-1:0] sat30(input logic signed [DataW+1:0] v);
		begin
			if (v > 32'(VMax)) return VMax;
			if (v < 32'(VMin)) return VMin;
			return v[DataW-1:0];
		end
	endfunction

	typedef struct packed {
		logic start;
		logic signed [DataW-1:0] er;
		logic signed [DataW-1:0] ei;
		logic signed [DataW-1:0] orr;
		logic signed [DataW-1:0] oi;
	} bfly_req_t;
endpackage
`default_nettype wire

// ----- src/r2fft_bfly.sv -----
`timescale 1ns / 1ps
`default_nettype none
module r2fft_bfly (
	input wire logic clk,
	input wire logic arst_n,
	input wire r2fft_pkg::bfly_req_t req,
	input wire r2fft_pkg::tw_t tw,
	output logic done,
	output logic signed [r2fft_pkg::DataW-1:0] ar,
	output logic signed [r2fft_pkg::DataW-1:0] ai,
	output logic signed [r2fft_pkg::DataW-1:0] br,
	output logic signed [r2fft_pkg::DataW-1:0] bi
);
	localparam int W = r2fft_pkg::DataW;
	// stage 1: four products, stage 2: round and add
	logic signed [W+r2fft_pkg::TwW-1:0] p_rr_s1, p_ii_s1, p_ri_s1, p_ir_s1;
	logic signed [W-1:0] er_s1, ei_s1;
	logic v_s1;
	logic signed [W+r2fft_pkg::TwW:0] tr_full, ti_full;
	logic signed [W+1:0] tr, ti;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s1 <= req.start;
			done <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		p_rr_s1 <= tw.re * req.orr;
		p_ii_s1 <= tw.im * req.oi;
		p_ri_s1 <= tw.re * req.oi;
		p_ir_s1 <= tw.im * req.orr;
		er_s1 <= req.er;
		ei_s1 <= req.ei;
	end

	always_comb begin
		tr_full = (p_rr_s1 - p_ii_s1 + (W + r2fft_pkg::TwW + 1)'(16384)) >>> 15;
		ti_full = (p_ri_s1 + p_ir_s1 + (W + r2fft_pkg::TwW + 1)'(16384)) >>> 15;
		tr = tr_full[W+1:0];
		ti = ti_full[W+1:0];
	end

	always_ff @(posedge clk) begin
		ar <= r2fft_pkg::sat30((W+2)'(er_s1) + tr);
		ai <= r2fft_pkg::sat30((W+2)'(ei_s1) + ti);
		br <= r2fft_pkg::sat30((W+2)'(er_s1) - tr);
		bi <= r2fft_pkg::sat30((W+2)'(ei_s1) - ti);
	end
endmodule
`default_nettype wire

// ----- src/radix2_fft_forward_inverse_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// loads one sample per cycle into a dual-port frame ram at bit-reversed addresses, then pads
// the frame with zeros up to n points and runs log2(n) passes of n/2 butterflies, each
// butterfly on one shared unit (read, wait, multiply-add, write back), then emits n bins,
// each read from the ram and then registered; out_ready low stretches the emit phase.
// in_ready is high only in the load phase. reset clears the sequencer, counters, mode and
// output registers, but not the frame ram
module radix2_fft_forward_inverse_core #(
	parameter int MAX_POINTS = r2fft_pkg::MaxPointsDefault
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic cfg_wdata,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic signed [23:0] sample_real,
	input wire logic signed [23:0] sample_imag,
	input wire logic frame_end,
	output logic out_valid,
	input wire logic out_ready,
	output logic signed [29:0] bin_real,
	output logic signed [29:0] bin_imag,
	output logic result_last
);
	localparam int W = r2fft_pkg::DataW;
	localparam int CapA = (MAX_POINTS < r2fft_pkg::TwSpan) ? MAX_POINTS : r2fft_pkg::TwSpan;
	localparam int LgCap = $clog2(CapA + 1) - 1;
	localparam int Cap = 1 << LgCap;
	localparam int AW = (LgCap < 1) ? 1 : LgCap;
	localparam int TwAW = (LgCap < 2) ? 1 : LgCap - 1;
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int LW = $clog2(LgCap + 1);

	typedef enum logic [7:0] {
		ST_LOAD = 8'b00000001,
		ST_PAD = 8'b00000010,
		ST_RD = 8'b00000100,
		ST_WAIT = 8'b00001000,
		ST_MUL = 8'b00010000,
		ST_WR = 8'b00100000,
		ST_EMIT = 8'b01000000,
		ST_EWAIT = 8'b10000000
	} state_t;

	state_t state_q;
	logic inv_cfg_q, inv_q;
	logic [CW-1:0] cnt_q;
	logic [AW:0] n_q, pad_q;
	logic [LW-1:0] lg_q, stage_q;
	logic [AW:0] bf_q, emit_q;
	logic [2:0] wc_q;

	// twiddle rom
	r2fft_pkg::tw_t tw_rom [Cap/2 > 0 ? Cap/2 : 1];
	always_comb begin
		for (int k = 0; k < (Cap/2 > 0 ? Cap/2 : 1); k++)
			tw_rom[k] = r2fft_pkg::twiddle(k * (r2fft_pkg::TwSpan / Cap));
	end

	// frame ram, real and imag packed, two ports
	logic [2*W-1:0] ram [Cap];
	logic [AW-1:0] ra_a, ra_b, wa;
	logic [2*W-1:0] rd_a_q, rd_b_q, wd;
	logic we, re;
	logic [AW-1:0] wa2;
	logic [2*W-1:0] wd2;
	logic we2;
	always_ff @(posedge clk) begin
		if (we) ram[wa] <= wd;
		if (we2) ram[wa2] <= wd2;
		if (re) begin
			rd_a_q <= ram[ra_a];
			rd_b_q <= ram[ra_b];
		end
	end

	// butterfly addressing: stage s, index b -> half=2^s
	// a frame of n points sits at every (Cap/n)-th ram entry
	logic [AW:0] half, blk, kk, e_idx, o_idx, tw_idx;
	logic [LW-1:0] sh;
	logic [AW:0] e_phys, o_phys, emit_phys;
	always_comb begin
		half = (AW+1)'(1) << stage_q;
		kk = bf_q & (half - 1'b1);
		blk = (bf_q >> stage_q) << (stage_q + 1'b1);
		e_idx = blk + kk;
		o_idx = e_idx + half;
		tw_idx = kk << (LW'(LgCap - 1) - stage_q);
		sh = LW'(LgCap) - lg_q;
		e_phys = e_idx << sh;
		o_phys = o_idx << sh;
		emit_phys = emit_q << sh;
	end

	function automatic logic [AW-1:0] brev(input logic [AW-1:0] i, input logic [LW-1:0] lg);
		logic [AW-1:0] r;
		begin
			r = '0;
			for (int b = 0; b < AW; b++)
				if (b < lg) r[lg-1-b] = i[b];
			return r;
		end
	endfunction

	r2fft_pkg::bfly_req_t req;
	r2fft_pkg::tw_t tw_s;
	logic bf_done;
	logic signed [W-1:0] ar, ai, br, bi;
	logic [AW-1:0] e_q, o_q;

	always_comb begin
		req.start = (state_q == ST_MUL) && (wc_q == 3'd0);
		req.er = rd_a_q[2*W-1:W];
		req.ei = rd_a_q[W-1:0];
		req.orr = rd_b_q[2*W-1:W];
		req.oi = rd_b_q[W-1:0];
		tw_s = tw_rom[tw_idx[TwAW-1:0]];
	end
	// rom entry k holds the twiddle for angle index k*TwSpan/Cap
	r2fft_bfly u_bfly (
		.clk(clk), .arst_n(arst_n), .req(req), .tw(tw_s), .done(bf_done),
		.ar(ar), .ai(ai), .br(br), .bi(bi)
	);

	logic load_acc, last_in;
	assign in_ready = (state_q == ST_LOAD);
	assign load_acc = in_valid && in_ready;
	assign last_in = frame_end || (cnt_q == CW'(MAX_POINTS - 1));

	logic [CW-1:0] cnt_new, cnt_eff;
	logic [AW:0] n_new;
	logic [LW-1:0] lg_new;
	always_comb begin
		cnt_new = cnt_q + 1'b1;
		cnt_eff = (cnt_new > CW'(Cap)) ? CW'(Cap) : cnt_new;
		n_new = (AW+1)'(1);
		lg_new = '0;
		for (int l = 0; l <= LgCap; l++)
			if (((AW+1)'(1) << l) < (AW+1)'(cnt_eff)) begin
				n_new = (AW+1)'(1) << (l + 1);
				lg_new = LW'(l + 1);
			end
	end

	// inverse input is conjugated on the way in, forward imag is dropped
	logic signed [W-1:0] im_load;
	assign im_load = inv_cfg_q ? -((W)'(sample_imag)) : '0;

	always_comb begin
		we = 1'b0; wa = '0; wd = '0;
		we2 = 1'b0; wa2 = '0; wd2 = '0;
		ra_a = '0; ra_b = '0;
		re = 1'b0;
		if (load_acc && cnt_q < CW'(Cap)) begin
			we = 1'b1;
			wa = brev(cnt_q[AW-1:0], LW'(LgCap));
			wd = {(W)'(sample_real), im_load};
		end
		if (state_q == ST_PAD && pad_q < n_q) begin
			we = 1'b1;
			wa = brev(pad_q[AW-1:0], LW'(LgCap));
			wd = '0;
		end
		if (state_q == ST_RD) begin
			re = 1'b1;
			ra_a = e_phys[AW-1:0];
			ra_b = o_phys[AW-1:0];
		end
		if (state_q == ST_WR) begin
			we = 1'b1; wa = e_q; wd = {ar, ai};
			we2 = 1'b1; wa2 = o_q; wd2 = {br, bi};
		end
		if (state_q == ST_EMIT) begin
			re = 1'b1;
			ra_a = emit_phys[AW-1:0];
		end
	end

	logic out_v_q;
	logic signed [W-1:0] obr_q, obi_q;
	logic olast_q;
	logic emit_fire;
	assign out_valid = out_v_q;
	assign bin_real = obr_q;
	assign bin_imag = obi_q;
	assign result_last = olast_q;
	assign emit_fire = (state_q == ST_EWAIT) && (!out_v_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			inv_cfg_q <= 1'b0;
			inv_q <= 1'b0;
			cnt_q <= '0;
			n_q <= '0;
			pad_q <= '0;
			lg_q <= '0;
			stage_q <= '0;
			bf_q <= '0;
			emit_q <= '0;
			wc_q <= '0;
			e_q <= '0;
			o_q <= '0;
			out_v_q <= 1'b0;
			obr_q <= '0;
			obi_q <= '0;
			olast_q <= 1'b0;
		end else begin
			if (cfg_we) inv_cfg_q <= cfg_wdata;
			if (emit_fire) out_v_q <= 1'b1;
			else if (out_ready) out_v_q <= 1'b0;
			case (state_q)
				ST_LOAD: if (load_acc) begin
					if (last_in) begin
						cnt_q <= '0;
						n_q <= n_new;
						lg_q <= lg_new;
						inv_q <= inv_cfg_q;
						pad_q <= (AW+1)'(cnt_eff);
						state_q <= ST_PAD;
					end else cnt_q <= cnt_new;
				end
				ST_PAD: begin
					if (pad_q >= n_q) begin
						stage_q <= '0;
						bf_q <= '0;
						state_q <= (lg_q == '0) ? ST_EMIT : ST_RD;
						emit_q <= '0;
					end else pad_q <= pad_q + 1'b1;
				end
				ST_RD: state_q <= ST_WAIT;
				ST_WAIT: begin
					e_q <= e_phys[AW-1:0];
					o_q <= o_phys[AW-1:0];
					wc_q <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					wc_q <= wc_q + 1'b1;
					if (bf_done) state_q <= ST_WR;
				end
				ST_WR: begin
					if (bf_q == (n_q >> 1) - 1'b1) begin
						bf_q <= '0;
						if (stage_q == lg_q - 1'b1) begin
							emit_q <= '0;
							state_q <= ST_EMIT;
						end else begin
							stage_q <= stage_q + 1'b1;
							state_q <= ST_RD;
						end
					end else begin
						bf_q <= bf_q + 1'b1;
						state_q <= ST_RD;
					end
				end
				ST_EMIT: state_q <= ST_EWAIT;
				ST_EWAIT: if (emit_fire) begin
					olast_q <= (emit_q == n_q - 1'b1);
					if (inv_q) begin
						obr_q <= $signed(rd_a_q[2*W-1:W]) >>> lg_q;
						obi_q <= '0;
					end else begin
						obr_q <= rd_a_q[2*W-1:W];
						obi_q <= rd_a_q[W-1:0];
					end
					if (emit_q == n_q - 1'b1) state_q <= ST_LOAD;
					else begin
						emit_q <= emit_q + 1'b1;
						state_q <= ST_EMIT;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) load_acc |-> state_q == ST_LOAD)
		else $error("load outside load phase");
	assert property (@(posedge clk) disable iff (!arst_n) out_valid && !out_ready |=> out_valid)
		else $error("result dropped");
	assert property (@(posedge clk) disable iff (!arst_n) state_q == ST_RD |-> e_idx < n_q)
		else $error("butterfly address out of frame");
endmodule
`default_nettype wire

// ----- tb/fft_frame_checker.sv -----
`timescale 1ns / 1ps
module fft_frame_checker (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic cfg_wdata,
	input logic in_valid,
	input logic in_ready,
	input logic signed [23:0] sample_real,
	input logic signed [23:0] sample_imag,
	input logic frame_end,
	input logic out_valid,
	input logic out_ready,
	input logic signed [29:0] bin_real,
	input logic signed [29:0] bin_imag,
	input logic result_last,
	output int fail_count,
	output int pending
);
	localparam int FrameMax = 64;
	localparam int AngleBits = 12;
	localparam int AngleSpan = 4096;
	localparam longint Max30 = 536870911;
	localparam longint Min30 = -536870912;

	typedef struct packed {
		logic signed [29:0] re;
		logic signed [29:0] im;
		logic last;
	} fft_bin_t;

	fft_bin_t bin_queue[$];
	logic signed [29:0] frame_re[FrameMax];
	logic signed [29:0] frame_im[FrameMax];
	longint work_re[FrameMax];
	longint work_im[FrameMax];
	int loaded;
	logic inverse_sel;

	function automatic longint round_down(input longint x, input int s);
		return x >>> s;
	endfunction

	function automatic longint round_half(input longint x, input int s);
		return (x + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	function automatic longint clip(input longint v, input longint lo, input longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	// q30 rotation by pi*2^j/2048
	function automatic longint rot_cos(input int j);
		case (j)
			0: return 1073740561;
			1: return 1073736771;
			2: return 1073721611;
			3: return 1073660973;
			4: return 1073418433;
			5: return 1072448455;
			6: return 1068571464;
			7: return 1053110176;
			8: return 992008094;
			9: return 759250125;
			10: return 0;
			default: return -1073741824;
		endcase
	endfunction

	function automatic longint rot_sin(input int j);
		case (j)
			0: return 1647099;
			1: return 3294193;
			2: return 6588356;
			3: return 13176464;
			4: return 26350944;
			5: return 52686014;
			6: return 105245103;
			7: return 209476638;
			8: return 410903207;
			9: return 759250125;
			10: return 1073741824;
			default: return 0;
		endcase
	endfunction

	task automatic root_of_unity(input int t, output longint wr, output longint wi);
		longint a, b, na, nb;
		a = longint'(1) <<< 30;
		b = 0;
		for (int j = 0; j < AngleBits; j++) begin
			if ((t >> j) & 1) begin
				na = round_half(a * rot_cos(j) + b * rot_sin(j), 30);
				nb = round_half(b * rot_cos(j) - a * rot_sin(j), 30);
				a = na;
				b = nb;
			end
		end
		wr = clip(round_half(a, 15), -32768, 32767);
		wi = clip(round_half(b, 15), -32768, 32767);
	endtask

	task automatic predict_spectrum();
		int n, lg, r, half, stride, e, o;
		longint wr, wi, tr, ti, er, ei, or_v, oi, tmp;
		fft_bin_t b;
		n = 1;
		lg = 0;
		while (n < loaded) begin
			n = n * 2;
			lg++;
		end
		for (int i = 0; i < n; i++) begin
			work_re[i] = i < loaded ? longint'(frame_re[i]) : 0;
			work_im[i] = (i < loaded && inverse_sel) ? -longint'(frame_im[i]) : 0;
		end
		for (int i = 0; i < n; i++) begin
			r = 0;
			for (int k = 0; k < lg; k++) r = r | (((i >> k) & 1) << (lg - 1 - k));
			if (r > i) begin
				tmp = work_re[i]; work_re[i] = work_re[r]; work_re[r] = tmp;
				tmp = work_im[i]; work_im[i] = work_im[r]; work_im[r] = tmp;
			end
		end
		for (int len = 2; len <= n; len = len * 2) begin
			half = len / 2;
			stride = AngleSpan / len;
			for (int st = 0; st < n; st += len) begin
				for (int k = 0; k < half; k++) begin
					e = st + k;
					o = e + half;
					root_of_unity(k * stride, wr, wi);
					er = work_re[e]; ei = work_im[e];
					or_v = work_re[o]; oi = work_im[o];
					tr = round_half(wr * or_v - wi * oi, 15);
					ti = round_half(wr * oi + wi * or_v, 15);
					work_re[e] = clip(er + tr, Min30, Max30);
					work_im[e] = clip(ei + ti, Min30, Max30);
					work_re[o] = clip(er - tr, Min30, Max30);
					work_im[o] = clip(ei - ti, Min30, Max30);
				end
			end
		end
		for (int i = 0; i < n; i++) begin
			b.re = 30'(inverse_sel ? round_down(work_re[i], lg) : work_re[i]);
			b.im = inverse_sel ? 30'sd0 : 30'(work_im[i]);
			b.last = (i + 1 == n);
			bin_queue.push_back(b);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		fft_bin_t exp_bin;
		if (!arst_n) begin
			loaded = 0;
			inverse_sel = 1'b0;
			fail_count = 0;
			pending = 0;
		end else begin
			if (cfg_we) inverse_sel = cfg_wdata;
			if (in_valid && in_ready) begin
				if (loaded < FrameMax) begin
					frame_re[loaded] = 30'(sample_real);
					frame_im[loaded] = 30'(sample_imag);
					loaded = loaded + 1;
				end
				if (frame_end || loaded == FrameMax) begin
					predict_spectrum();
					loaded = 0;
				end
			end
			if (out_valid && out_ready) begin
				if (bin_queue.size() == 0) begin
					fail_count = fail_count + 1;
					if (fail_count <= 10)
						$display("%0t: unexpected output transaction re=%0d im=%0d last=%0b",
							$time, bin_real, bin_imag, result_last);
				end else begin
					exp_bin = bin_queue.pop_front();
					if (exp_bin.re !== bin_real || exp_bin.im !== bin_imag ||
						exp_bin.last !== result_last) begin
						fail_count = fail_count + 1;
						if (fail_count <= 10)
							$display("%0t: bin mismatch exp re=%0d im=%0d last=%0b got re=%0d im=%0d last=%0b",
								$time, exp_bin.re, exp_bin.im, exp_bin.last,
								bin_real, bin_imag, result_last);
					end
				end
			end
			pending = bin_queue.size();
		end
	end
endmodule

// ----- tb/tb_radix2_fft_forward_inverse_core.sv -----
`timescale 1ns / 1ps
module tb_radix2_fft_forward_inverse_core;
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_wdata = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [r2fft_pkg::InW-1:0] sample_real = '0;
	logic signed [r2fft_pkg::InW-1:0] sample_imag = '0;
	logic frame_end = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [r2fft_pkg::DataW-1:0] bin_real;
	logic signed [r2fft_pkg::DataW-1:0] bin_imag;
	logic result_last;
	int fail_count;
	int pending;

	int snd_idle = 22;
	int rcv_idle = 79;
	int items_sent = 0;
	int frames_sent = 0;
	int inv_frames = 0;
	bit held = 0;
	logic mode_now = 1'b0;

	radix2_fft_forward_inverse_core u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .sample_real(sample_real),
		.sample_imag(sample_imag), .frame_end(frame_end), .out_valid(out_valid),
		.out_ready(out_ready), .bin_real(bin_real), .bin_imag(bin_imag),
		.result_last(result_last)
	);

	fft_frame_checker u_checker (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .sample_real(sample_real),
		.sample_imag(sample_imag), .frame_end(frame_end), .out_valid(out_valid),
		.out_ready(out_ready), .bin_real(bin_real), .bin_imag(bin_imag),
		.result_last(result_last), .fail_count(fail_count), .pending(pending)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("timeout with %0d bins outstanding", pending);
		$display("FAILURE");
		$finish;
	end

	// receiver; one long hold-off lets the core back up into its input
	initial begin
		forever begin
			@(posedge clk);
			if (items_sent >= 190 && !held) begin
				held = 1;
				out_ready <= 1'b0;
				repeat (3000) @(posedge clk);
			end
			out_ready <= ($urandom_range(99) >= rcv_idle);
		end
	end

	function automatic logic signed [r2fft_pkg::InW-1:0] pick_sample();
		case ($urandom_range(5))
			0: return 24'sh7fffff;
			1: return 24'sh800000;
			2: return $signed(24'($urandom_range(255))) - 24'sd128;
			default: return 24'($urandom);
		endcase
	endfunction

	task automatic push_sample(input logic signed [r2fft_pkg::InW-1:0] re,
		input logic signed [r2fft_pkg::InW-1:0] im, input logic last);
		if ($urandom_range(99) < snd_idle) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample_real <= re;
		sample_imag <= im;
		frame_end <= last;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		items_sent++;
		if (items_sent == 77) begin
			snd_idle = 79;
			rcv_idle = 22;
		end else if (items_sent == 154) begin
			snd_idle = 0;
			rcv_idle = 0;
		end
	endtask

	// len 64 without a marker ends on the count alone
	task automatic push_frame(input int len, input bit marked);
		for (int i = 0; i < len; i++)
			push_sample(pick_sample(), pick_sample(), marked && (i == len - 1));
		frames_sent++;
		if (mode_now) inv_frames++;
	endtask

	task automatic push_const_frame(input int len,
		input logic signed [r2fft_pkg::InW-1:0] re,
		input logic signed [r2fft_pkg::InW-1:0] im);
		for (int i = 0; i < len; i++) push_sample(re, im, i == len - 1);
		frames_sent++;
		if (mode_now) inv_frames++;
	endtask

	task automatic drain_and_set_mode(input logic mode);
		@(posedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= mode;
		@(posedge clk);
		cfg_we <= 1'b0;
		mode_now = mode;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		drain_and_set_mode(1'b0);
		push_const_frame(1, 24'sh7fffff, 24'sh800000);
		push_const_frame(1, 24'sh800000, 24'sh7fffff);
		push_const_frame(2, 24'sh7fffff, 24'sh0);
		push_frame(3, 1);
		push_const_frame(4, 24'sh800000, 24'sh800000);
		drain_and_set_mode(1'b1);
		push_const_frame(1, 24'sh800000, 24'sh7fffff);
		push_const_frame(2, 24'sh7fffff, 24'sh800000);
		push_frame(5, 1);
		push_const_frame(4, 24'sh800000, 24'sh800000);

		for (int ph = 0; ph < 6; ph++) begin
			drain_and_set_mode(ph % 2 == 0 ? 1'b0 : 1'b1);
			while (items_sent < 24 + (ph + 1) * 33) begin
				case ($urandom_range(9))
					0: push_frame(64, $urandom_range(1));
					1, 2: push_frame($urandom_range(32, 9), 1);
					default: push_frame($urandom_range(8, 1), 1);
				endcase
			end
		end

		@(posedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		$display("%0d samples in %0d frames (%0d inverse), lengths 1 to 64 incl. auto-ended",
			items_sent, frames_sent, inv_frames);
		if (fail_count == 0 && pending == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d mismatches, %0d bins outstanding", fail_count, pending);
			$display("FAILURE");
		end
		$finish;
	end
endmodule

// ----- files.f -----
src/r2fft_pkg.sv
src/r2fft_bfly.sv
src/radix2_fft_forward_inverse_core.sv
tb/fft_frame_checker.sv
tb/tb_radix2_fft_forward_inverse_core.sv
